### sv/psfd_pkg.sv
// ----------------------------------------------------------------------------
// psfd_pkg
// Shared constants, types and the packet classifier of the flood detector.
// ----------------------------------------------------------------------------
`default_nettype none
package psfd_pkg;
    localparam int SOURCES_DEF = 32;
    localparam int CATS        = 6;
    localparam int CNT_W       = 16;
    localparam int IP_W        = 32;
    localparam int NREGS       = 6;
    localparam int ADDR_W      = 5;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [CNT_W-1:0] LIMIT_RESET [CATS] =
        '{16'd1, 16'd1, 16'd20, 16'd10, 16'd20, 16'd20};

    typedef struct packed {
        logic            tick;
        logic [IP_W-1:0] ip;
        logic [CATS-1:0] cats;
    } t_cmd;

    function automatic logic [CATS-1:0] classify(input logic [7:0] proto,
                                                 input logic [7:0] fl);
        logic [CATS-1:0] m;
        logic fin, syn, rst, psh, ack, urg;
        m   = '0;
        fin = fl[0];
        syn = fl[1];
        rst = fl[2];
        psh = fl[3];
        ack = fl[4];
        urg = fl[5];
        m[0] = (proto == PROTO_UDP);
        m[1] = (proto == PROTO_ICMP);
        if (proto == PROTO_TCP) begin
            m[2] = syn & ~ack;
            m[3] = fin & urg & psh & ~syn & ~ack;
            m[4] = fin & ~syn;
            m[5] = ~syn & ~ack & ~fin & ~rst;
        end
        return m;
    endfunction
endpackage
`default_nettype wire

### sv/psfd_front.sv
// ----------------------------------------------------------------------------
// psfd_front
// Accepts words, classifies packets and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none
module psfd_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_func,
    input  wire logic [31:0]      i_src_ip,
    input  wire logic [7:0]       i_protocol,
    input  wire logic [7:0]       i_tcp_flags,
    output logic                  o_cmd_valid,
    output psfd_pkg::t_cmd        o_cmd,
    input  wire logic             i_cmd_take
);
    psfd_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       acc, keep;
    psfd_pkg::t_cmd c;

    assign o_stall     = (r_cnt == 2'd2);
    assign acc         = i_valid & ~o_stall;
    assign c.tick      = i_func;
    assign c.ip        = i_src_ip;
    assign c.cats      = psfd_pkg::classify(i_protocol, i_tcp_flags);
    assign keep        = acc & (i_func | (c.cats != '0));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (keep) begin
                r_q[r_wr] <= c;
                r_wr      <= ~r_wr;
            end
            if (i_cmd_take) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, keep} - {1'b0, i_cmd_take};
        end
    end
endmodule
`default_nettype wire

### sv/psfd_back.sv
// ----------------------------------------------------------------------------
// psfd_back
// Source table, counter update and the report walk run on a tick.
// ----------------------------------------------------------------------------
`default_nettype none
module psfd_back #(
    parameter int SOURCES = psfd_pkg::SOURCES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  psfd_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_take,
    input  wire logic [16*6-1:0]       i_limits,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [31:0]                o_report_ip,
    output logic [5:0]                 o_over_mask,
    output logic [16*6-1:0]            o_seen,
    output logic [15:0]                o_dropped_packets,
    output logic                       o_last
);
    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CW = psfd_pkg::CNT_W;
    localparam int NC = psfd_pkg::CATS;

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_WALK, S_CLOSE} t_state;
    t_state r_state;

    logic [SOURCES-1:0] r_used;
    logic [31:0]        r_addr [SOURCES];
    logic [NC*CW-1:0]   r_cnt_mem [SOURCES];
    logic [NC*CW-1:0]   r_rdata;
    logic [SW-1:0]      r_slot;
    logic               r_new;
    logic [NC-1:0]      r_cats;
    logic [15:0]        r_drop;
    logic [SW:0]        r_walk;
    logic [SW:0]        r_rdidx;
    logic               r_rdv;

    logic [SOURCES-1:0] hit;
    logic               any_hit, any_free;
    logic [SW-1:0]      hit_idx, free_idx;
    logic [NC*CW-1:0]   upd;
    logic [NC-1:0]      mask;
    logic               out_free;
    logic               emit;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        any_hit  = 1'b0;
        any_free = 1'b0;
        for (int i = SOURCES - 1; i >= 0; i--) begin
            hit[i] = r_used[i] & (r_addr[i] == i_cmd.ip);
            if (hit[i]) begin
                any_hit = 1'b1;
                hit_idx = SW'(i);
            end
            if (!r_used[i]) begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            logic [CW-1:0] v;
            v = r_new ? '0 : r_rdata[c*CW +: CW];
            if (r_cats[c] && v != {CW{1'b1}}) v = v + 1'b1;
            upd[c*CW +: CW] = v;
            mask[c] = r_rdata[c*CW +: CW] > i_limits[c*CW +: CW];
        end
    end

    assign out_free   = ~o_valid | ~i_stall;
    assign emit       = r_rdv & r_used[r_rdidx[SW-1:0]] & (mask != '0);
    assign o_cmd_take = (r_state == S_IDLE) & i_cmd_valid &
                        ~(i_cmd.tick & 1'b0);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_cnt_mem[(r_state == S_IDLE) ? (any_hit ? hit_idx : free_idx)
                             : (out_free ? r_walk[SW-1:0] : r_rdidx[SW-1:0])];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_drop  <= '0;
            o_valid <= 1'b0;
            r_rdv   <= 1'b0;
            r_walk  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_stall) o_valid <= 1'b0;
                    if (i_cmd_valid) begin
                        if (i_cmd.tick) begin
                            r_walk  <= '0;
                            r_rdv   <= 1'b0;
                            r_state <= S_WALK;
                        end else if (any_hit || any_free) begin
                            r_slot <= any_hit ? hit_idx : free_idx;
                            r_new  <= ~any_hit;
                            r_cats <= i_cmd.cats;
                            if (!any_hit) begin
                                r_used[free_idx] <= 1'b1;
                                r_addr[free_idx] <= i_cmd.ip;
                            end
                            r_state <= S_UPD;
                        end else if (r_drop != 16'hFFFF) begin
                            r_drop <= r_drop + 16'd1;
                        end
                    end
                end
                S_UPD: begin
                    if (!i_stall) o_valid <= 1'b0;
                    r_cnt_mem[r_slot] <= upd;
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    if (out_free) begin
                        o_valid <= emit;
                        if (emit) begin
                            o_report_ip       <= r_addr[r_rdidx[SW-1:0]];
                            o_over_mask       <= mask;
                            o_seen            <= r_rdata;
                            o_dropped_packets <= r_drop;
                            o_last            <= 1'b0;
                        end
                        r_rdidx <= r_walk;
                        r_rdv   <= (r_walk != (SW+1)'(SOURCES));
                        if (r_walk == (SW+1)'(SOURCES)) begin
                            r_state <= S_CLOSE;
                        end else begin
                            r_walk <= r_walk + 1'b1;
                        end
                    end
                end
                S_CLOSE: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        if (emit) begin
                            o_report_ip       <= r_addr[r_rdidx[SW-1:0]];
                            o_over_mask       <= mask;
                            o_seen            <= r_rdata;
                            o_dropped_packets <= r_drop;
                            o_last            <= 1'b0;
                            r_rdv             <= 1'b0;
                        end else begin
                            o_report_ip       <= '0;
                            o_over_mask       <= '0;
                            o_seen            <= '0;
                            o_dropped_packets <= r_drop;
                            o_last            <= 1'b1;
                            r_used            <= '0;
                            r_drop            <= '0;
                            r_state           <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/per_source_flood_detector.sv
// ----------------------------------------------------------------------------
// per_source_flood_detector
// Per-source packet category counters with one-second threshold reports.
//
//   channel | direction | handshake
//   input   | in        | i_valid / o_stall
//   output  | out       | o_valid / i_stall
//   config  | in        | APB, registers at 4*i
//
// A packet word passes two back-end states: slot match and counter read,
// then the counter write; a packet that finds the table full is only counted
// as dropped. A tick is accepted, the walk then reads each slot in turn
// behind a registered read, and the closing word follows; an output stall
// holds the walk. Reset is synchronous; the output register holds while
// stalled and a two-word queue parts the sides.
// ----------------------------------------------------------------------------
`default_nettype none
module per_source_flood_detector #(
    parameter int SOURCES = psfd_pkg::SOURCES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [7:0]  i_tcp_flags,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_report_ip,
    output logic [5:0]       o_over_mask,
    output logic [15:0]      o_udp_seen,
    output logic [15:0]      o_icmp_seen,
    output logic [15:0]      o_syn_seen,
    output logic [15:0]      o_xmas_seen,
    output logic [15:0]      o_fin_seen,
    output logic [15:0]      o_null_seen,
    output logic [15:0]      o_dropped_packets,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0]     r_lim [psfd_pkg::NREGS];
    logic [16*6-1:0] lims, seen;
    logic            cmd_valid, cmd_take;
    psfd_pkg::t_cmd  cmd;
    logic [2:0]      ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < psfd_pkg::NREGS; k++) r_lim[k] <= psfd_pkg::LIMIT_RESET[k];
        end else if (psel && penable && pwrite && ridx < 3'(psfd_pkg::NREGS)) begin
            r_lim[ridx] <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (ridx < 3'(psfd_pkg::NREGS)) prdata = {16'd0, r_lim[ridx]};
        for (int k = 0; k < 6; k++) lims[k*16 +: 16] = r_lim[k];
    end

    psfd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_src_ip(i_src_ip), .i_protocol(i_protocol),
        .i_tcp_flags(i_tcp_flags), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_take(cmd_take)
    );

    psfd_back #(.SOURCES(SOURCES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .i_limits(lims), .o_valid(o_valid),
        .i_stall(i_stall), .o_report_ip(o_report_ip), .o_over_mask(o_over_mask),
        .o_seen(seen), .o_dropped_packets(o_dropped_packets), .o_last(o_last)
    );

    assign o_udp_seen  = seen[15:0];
    assign o_icmp_seen = seen[31:16];
    assign o_syn_seen  = seen[47:32];
    assign o_xmas_seen = seen[63:48];
    assign o_fin_seen  = seen[79:64];
    assign o_null_seen = seen[95:80];
endmodule
`default_nettype wire

### tb/sv/flood_checker.sv
// ----------------------------------------------------------------------------
// flood_checker
// Watches the packet and report channels of the flood detector, keeps its own
// per-source category table, predicts every report run on a tick and compares
// each report word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module flood_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_src_ip,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [7:0]  i_tcp_flags,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_report_ip,
    input  wire logic [5:0]  i_over_mask,
    input  wire logic [15:0] i_udp_seen,
    input  wire logic [15:0] i_icmp_seen,
    input  wire logic [15:0] i_syn_seen,
    input  wire logic [15:0] i_xmas_seen,
    input  wire logic [15:0] i_fin_seen,
    input  wire logic [15:0] i_null_seen,
    input  wire logic [15:0] i_dropped_packets,
    input  wire logic        i_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_val,
    output int               o_errors,
    output int               o_pending
);
    localparam int NSRC = psfd_pkg::SOURCES_DEF;
    localparam int CATS = psfd_pkg::CATS;

    typedef struct packed {
        logic [31:0]      ip;
        logic [5:0]       mask;
        logic [6*16-1:0]  seen;
        logic [15:0]      drops;
        logic             last;
    } t_report;

    logic [15:0] limit_q [CATS];
    logic        used_q  [NSRC];
    logic [31:0] addr_q  [NSRC];
    logic [15:0] count_q [NSRC][CATS];
    logic [15:0] drop_q;
    t_report     report_queue [$];

    assign o_pending = report_queue.size();

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_errors++;
    endtask

    task automatic count_packet(input logic [31:0] ip, input logic [7:0] proto,
                                input logic [7:0] fl);
        logic [5:0] cats;
        int slot;
        cats = 6'd0;
        slot = -1;
        if (proto == psfd_pkg::PROTO_UDP) cats[0] = 1'b1;
        if (proto == psfd_pkg::PROTO_ICMP) cats[1] = 1'b1;
        if (proto == psfd_pkg::PROTO_TCP) begin
            cats[2] = fl[1] && !fl[4];
            cats[3] = fl[0] && fl[5] && fl[3] && !fl[1] && !fl[4];
            cats[4] = fl[0] && !fl[1];
            cats[5] = !fl[1] && !fl[4] && !fl[0] && !fl[2];
        end
        if (cats == 6'd0) return;
        for (int i = 0; i < NSRC; i++)
            if (slot < 0 && used_q[i] && addr_q[i] == ip) slot = i;
        for (int i = 0; i < NSRC; i++)
            if (slot < 0 && !used_q[i]) begin
                slot = i;
                used_q[i] = 1'b1;
                addr_q[i] = ip;
                for (int c = 0; c < CATS; c++) count_q[i][c] = 16'd0;
            end
        if (slot < 0) begin
            if (drop_q != 16'hFFFF) drop_q++;
            return;
        end
        for (int c = 0; c < CATS; c++)
            if (cats[c] && count_q[slot][c] != 16'hFFFF) count_q[slot][c]++;
    endtask

    task automatic close_window();
        t_report r;
        for (int i = 0; i < NSRC; i++) begin
            if (!used_q[i]) continue;
            r = '0;
            for (int c = 0; c < CATS; c++) begin
                if (count_q[i][c] > limit_q[c]) r.mask[c] = 1'b1;
                r.seen[c*16 +: 16] = count_q[i][c];
            end
            if (r.mask != 6'd0) begin
                r.ip = addr_q[i];
                r.drops = drop_q;
                report_queue.insert(report_queue.size(), r);
            end
        end
        r = '0;
        r.drops = drop_q;
        r.last = 1'b1;
        report_queue.insert(report_queue.size(), r);
        for (int i = 0; i < NSRC; i++) used_q[i] = 1'b0;
        drop_q = 16'd0;
    endtask

    task automatic compare_word();
        t_report w;
        logic [6*16-1:0] got_seen;
        got_seen = {i_null_seen, i_fin_seen, i_xmas_seen, i_syn_seen,
                    i_icmp_seen, i_udp_seen};
        if (report_queue.size() == 0) begin
            report_error("unexpected word", i_report_ip, 32'd0);
            return;
        end
        w = report_queue.pop_front();
        if (i_report_ip != w.ip) report_error("report_ip", i_report_ip, w.ip);
        if (i_over_mask != w.mask)
            report_error("over_mask", 32'(i_over_mask), 32'(w.mask));
        if (got_seen[15:0] != w.seen[15:0])
            report_error("udp_seen", 32'(got_seen[15:0]), 32'(w.seen[15:0]));
        if (got_seen[31:16] != w.seen[31:16])
            report_error("icmp_seen", 32'(got_seen[31:16]), 32'(w.seen[31:16]));
        if (got_seen[47:32] != w.seen[47:32])
            report_error("syn_seen", 32'(got_seen[47:32]), 32'(w.seen[47:32]));
        if (got_seen[63:48] != w.seen[63:48])
            report_error("xmas_seen", 32'(got_seen[63:48]), 32'(w.seen[63:48]));
        if (got_seen[79:64] != w.seen[79:64])
            report_error("fin_seen", 32'(got_seen[79:64]), 32'(w.seen[79:64]));
        if (got_seen[95:80] != w.seen[95:80])
            report_error("null_seen", 32'(got_seen[95:80]), 32'(w.seen[95:80]));
        if (i_dropped_packets != w.drops)
            report_error("dropped_packets", 32'(i_dropped_packets), 32'(w.drops));
        if (i_last != w.last) report_error("last", 32'(i_last), 32'(w.last));
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CATS; c++) limit_q[c] = psfd_pkg::LIMIT_RESET[c];
            for (int i = 0; i < NSRC; i++) used_q[i] = 1'b0;
            drop_q = 16'd0;
            report_queue.delete();
        end else begin
            if (i_cfg_we && i_cfg_idx < CATS) limit_q[i_cfg_idx] = i_cfg_val;
            if (i_out_valid && !i_out_stall) compare_word();
            if (i_valid && !i_in_stall) begin
                if (i_func) close_window();
                else count_packet(i_src_ip, i_protocol, i_tcp_flags);
            end
        end
    end
endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives packet and tick words into the flood detector with bursty traffic,
// a stalling report receiver and limit changes between windows; the verdict
// comes from the failure count of the checker or from an idle timeout.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = 1'b0;
    logic [31:0] src_ip = '0;
    logic [7:0]  protocol = '0;
    logic [7:0]  tcp_flags = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] report_ip;
    logic [5:0]  over_mask;
    logic [15:0] udp_seen, icmp_seen, syn_seen, xmas_seen, fin_seen, null_seen;
    logic [15:0] dropped_packets;
    logic        last_word;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, idle_cycles;
    logic [31:0] ip_pool [8];

    always #6 i_clk = ~i_clk;

    per_source_flood_detector uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func), .i_src_ip(src_ip), .i_protocol(protocol),
        .i_tcp_flags(tcp_flags), .o_valid(out_valid), .i_stall(out_stall),
        .o_report_ip(report_ip), .o_over_mask(over_mask), .o_udp_seen(udp_seen),
        .o_icmp_seen(icmp_seen), .o_syn_seen(syn_seen), .o_xmas_seen(xmas_seen),
        .o_fin_seen(fin_seen), .o_null_seen(null_seen),
        .o_dropped_packets(dropped_packets), .o_last(last_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    flood_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_src_ip(src_ip), .i_protocol(protocol),
        .i_tcp_flags(tcp_flags), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_report_ip(report_ip), .i_over_mask(over_mask), .i_udp_seen(udp_seen),
        .i_icmp_seen(icmp_seen), .i_syn_seen(syn_seen), .i_xmas_seen(xmas_seen),
        .i_fin_seen(fin_seen), .i_null_seen(null_seen),
        .i_dropped_packets(dropped_packets), .i_last(last_word),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_idx(paddr[4:2]),
        .i_cfg_val(pwdata[15:0]), .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random with a density that changes now and then.
    int stall_pct = 30;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 3) * 25;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_limit(input int idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx * 4); pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    int burst_left = 0;

    task automatic send_word(input logic f, input logic [31:0] ip,
                             input logic [7:0] pr, input logic [7:0] fl);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1; func <= f; src_ip <= ip; protocol <= pr; tcp_flags <= fl;
        do @(posedge i_clk); while (in_stall);
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic send_packet(input logic [31:0] ip, input logic [7:0] pr,
                               input logic [7:0] fl);
        send_word(1'b0, ip, pr, fl);
    endtask

    task automatic end_window();
        send_word(1'b1, $urandom, 8'($urandom), 8'($urandom));
        if (burst_left != 0) begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_protocol();
        case ($urandom_range(0, 4))
            0: return psfd_pkg::PROTO_UDP;
            1: return psfd_pkg::PROTO_ICMP;
            2, 3: return psfd_pkg::PROTO_TCP;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_packet(32'h0000_0000, psfd_pkg::PROTO_UDP, 8'h00);
        send_packet(32'h0000_0000, psfd_pkg::PROTO_UDP, 8'h00);
        send_packet(32'hFFFF_FFFF, psfd_pkg::PROTO_ICMP, 8'hFF);
        send_packet(32'hFFFF_FFFF, psfd_pkg::PROTO_ICMP, 8'h00);
        send_packet(32'h0A00_0001, psfd_pkg::PROTO_TCP, 8'h02);
        send_packet(32'h0A00_0001, psfd_pkg::PROTO_TCP, 8'h12);
        send_packet(32'h0A00_0002, psfd_pkg::PROTO_TCP, 8'h29);
        send_packet(32'h0A00_0002, psfd_pkg::PROTO_TCP, 8'h01);
        send_packet(32'h0A00_0003, psfd_pkg::PROTO_TCP, 8'h00);
        send_packet(32'h0A00_0003, psfd_pkg::PROTO_TCP, 8'hC8);
        send_packet(32'h0A00_0004, psfd_pkg::PROTO_TCP, 8'h04);
        send_packet(32'h0A00_0005, 8'd50, 8'hFF);
        send_packet(32'h0A00_0005, psfd_pkg::PROTO_TCP, 8'h10);
        end_window();

        for (int c = 0; c < psfd_pkg::CATS; c++) write_limit(c, 16'd0);
        write_limit(6, 16'hFFFF);
        // Fill the table past its size so that new sources are dropped.
        for (int i = 0; i < 36; i++)
            send_packet(32'hC0A8_0000 + i, psfd_pkg::PROTO_UDP, 8'h00);
        end_window();

        for (int c = 0; c < psfd_pkg::CATS; c++) write_limit(c, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_packet(32'h1, psfd_pkg::PROTO_TCP, 8'h29);
        end_window();

        for (int w = 0; w < 8; w++) begin
            for (int c = 0; c < psfd_pkg::CATS; c++)
                write_limit(c, 16'($urandom_range(0, 4)));
            for (int k = 0; k < 8; k++) ip_pool[k] = $urandom;
            repeat ($urandom_range(15, 40)) begin
                if ($urandom_range(0, 9) < 8)
                    send_packet(ip_pool[$urandom_range(0, 7)], pick_protocol(),
                                8'($urandom));
                else
                    send_packet($urandom, pick_protocol(), 8'($urandom));
            end
            end_window();
        end
        for (int c = 0; c < psfd_pkg::CATS; c++) write_limit(c, psfd_pkg::LIMIT_RESET[c]);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
sv/psfd_pkg.sv
sv/psfd_front.sv
sv/psfd_back.sv
sv/per_source_flood_detector.sv
tb/sv/flood_checker.sv
tb/sv/tb.sv
